// ----- rtl/core/read_write_deadline_dispatcher_assert.svh -----
// Assertion macros shared by the dispatcher RTL.
`ifndef READ_WRITE_DEADLINE_DISPATCHER_ASSERT_SVH
`define READ_WRITE_DEADLINE_DISPATCHER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define RWDD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define RWDD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/rwdd_pkg.sv -----
// Shared constants, codes and payload types of the read/write deadline dispatcher.
package rwdd_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TIME_BITS   = 32;
    localparam int TAG_W       = 8;
    localparam int DL_W        = 16;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = PTR_W + 1;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = DL_W;

    localparam logic [DL_W-1:0] DEADLINE_RESET = DL_W'(10);

    typedef enum logic [2:0] {
        ACT_ADD_READ  = 3'd0,
        ACT_ADD_WRITE = 3'd1,
        ACT_DISPATCH  = 3'd2,
        ACT_COMPLETE  = 3'd3,
        ACT_TICK      = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_BUSY  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_READ_DEADLINE  = 2'd0,
        CFG_WRITE_DEADLINE = 2'd1,
        CFG_READ_PREDICT   = 2'd2,
        CFG_WRITE_PREDICT  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0]       action;
        logic [TAG_W-1:0] request_tag;
    } t_cmd;

    typedef struct packed {
        logic             dispatched;
        logic [TAG_W-1:0] issued_tag;
        logic             issued_is_write;
        t_status          status;
    } t_result;

    typedef struct packed {
        logic [TAG_W-1:0]     tag;
        logic [TIME_BITS-1:0] expiry;
    } t_entry;

endpackage

// ----- rtl/core/rwdd_queue.sv -----
// Circular request queue holding tags and expiry times, head visible combinationally.
`include "read_write_deadline_dispatcher_assert.svh"

module rwdd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  logic            i_pop,
    input  rwdd_pkg::t_entry i_entry,
    output rwdd_pkg::t_entry o_head,
    output logic            o_empty,
    output logic            o_full
);
    import rwdd_pkg::*;

    t_entry           r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_head;
    logic [PTR_W-1:0] n_head;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [PTR_W:0]   tail_sum;
    logic [PTR_W-1:0] w_tail;

    always_comb begin
        tail_sum = {1'b0, r_head} + (PTR_W + 1)'(r_count);
        if (tail_sum >= (PTR_W + 1)'(QUEUE_DEPTH)) begin
            w_tail = PTR_W'(tail_sum - (PTR_W + 1)'(QUEUE_DEPTH));
        end else begin
            w_tail = tail_sum[PTR_W-1:0];
        end
    end

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_pop) begin
            n_head  = (r_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
            n_count = r_count - 1'b1;
        end else if (i_push) begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[w_tail] <= i_entry;
        end
    end

    assign o_head  = r_mem[r_head];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));

    `RWDD_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, i_push, !o_full, "push into full queue")
    `RWDD_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, i_pop, !o_empty, "pop from empty queue")
    `RWDD_ASSERT_NXT(a_push_fills, i_clk, i_rst_n, i_push && !i_pop, !o_empty, "push left queue empty")

endmodule

// ----- rtl/core/read_write_deadline_dispatcher.sv -----
// Read/write deadline dispatcher: two deadline-tagged queues and dispatch arbitration.
// Each result and its o_done strobe are registered in r_out and r_out_valid after the decision.
// Throughput: one command per cycle; o_busy is never raised, the result path cannot stall.
// Each command is decided from the queue heads and counters in the cycle after its capture.
// Synchronous active-low reset empties both queues, clears time and in-flight state,
// and restores the deadline and predict registers to their defaults.
`include "read_write_deadline_dispatcher_assert.svh"

module read_write_deadline_dispatcher (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  rwdd_pkg::t_cmd                 i_cmd,
    output logic                           o_done,
    output rwdd_pkg::t_result              o_result,
    input  logic                           i_cfg_we,
    input  logic [rwdd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rwdd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rwdd_pkg::*;

    // capture stage
    logic                 r_in_valid;
    t_cmd                 r_in;

    // architectural state
    logic [TIME_BITS-1:0] r_time;
    logic [TIME_BITS-1:0] n_time;
    logic                 r_outstanding;
    logic                 n_outstanding;
    logic [DL_W-1:0]      r_rd_deadline;
    logic [DL_W-1:0]      r_wr_deadline;
    logic                 r_rd_predict_long;
    logic                 r_wr_predict_gc;

    // result stage
    logic                 r_out_valid;
    t_result              r_out;
    t_result              n_out;

    // queue interface
    logic                 rd_push;
    logic                 rd_pop;
    logic                 wr_push;
    logic                 wr_pop;
    t_entry               rd_entry;
    t_entry               wr_entry;
    t_entry               rd_head;
    t_entry               wr_head;
    logic                 rd_empty;
    logic                 rd_full;
    logic                 wr_empty;
    logic                 wr_full;

    logic [TIME_BITS+DL_W-1:0] rd_exp_sum;
    logic [TIME_BITS+DL_W-1:0] wr_exp_sum;
    logic [TIME_BITS-1:0] head_diff;
    logic [TIME_BITS-1:0] wr_age;
    logic [TIME_BITS-1:0] rd_age;
    logic                 write_older;
    logic                 wr_expired;
    logic                 rd_expired;
    logic                 take_write;

    assign o_busy = 1'b0;

    rwdd_queue u_rd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rd_push),
        .i_pop   (rd_pop),
        .i_entry (rd_entry),
        .o_head  (rd_head),
        .o_empty (rd_empty),
        .o_full  (rd_full)
    );

    rwdd_queue u_wr_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (wr_push),
        .i_pop   (wr_pop),
        .i_entry (wr_entry),
        .o_head  (wr_head),
        .o_empty (wr_empty),
        .o_full  (wr_full)
    );

    // expiry = now + deadline, wrapping at the time width
    always_comb begin
        rd_exp_sum      = (TIME_BITS + DL_W)'(r_time) + (TIME_BITS + DL_W)'(r_rd_deadline);
        wr_exp_sum      = (TIME_BITS + DL_W)'(r_time) + (TIME_BITS + DL_W)'(r_wr_deadline);
        rd_entry.tag    = r_in.request_tag;
        rd_entry.expiry = rd_exp_sum[TIME_BITS-1:0];
        wr_entry.tag    = r_in.request_tag;
        wr_entry.expiry = wr_exp_sum[TIME_BITS-1:0];
    end

    // wrap-aware head comparison
    always_comb begin
        head_diff   = wr_head.expiry - rd_head.expiry;
        wr_age      = r_time - wr_head.expiry;
        rd_age      = r_time - rd_head.expiry;
        write_older = head_diff[TIME_BITS-1];
        wr_expired  = !wr_age[TIME_BITS-1];
        rd_expired  = !rd_age[TIME_BITS-1];
        if (rd_empty) begin
            take_write = 1'b1;
        end else if (wr_empty) begin
            take_write = 1'b0;
        end else if (write_older) begin
            take_write = wr_expired || !r_wr_predict_gc;
        end else begin
            take_write = !rd_expired && r_rd_predict_long;
        end
    end

    always_comb begin
        rd_push       = 1'b0;
        wr_push       = 1'b0;
        rd_pop        = 1'b0;
        wr_pop        = 1'b0;
        n_time        = r_time;
        n_outstanding = r_outstanding;
        n_out         = '{dispatched: 1'b0, issued_tag: '0, issued_is_write: 1'b0,
                          status: ST_OK};
        if (r_in_valid) begin
            unique case (r_in.action)
                ACT_ADD_READ: begin
                    if (rd_full) begin
                        n_out.status = ST_FULL;
                    end else begin
                        rd_push = 1'b1;
                    end
                end
                ACT_ADD_WRITE: begin
                    if (wr_full) begin
                        n_out.status = ST_FULL;
                    end else begin
                        wr_push = 1'b1;
                    end
                end
                ACT_DISPATCH: begin
                    priority if (r_outstanding) begin
                        n_out.status = ST_BUSY;
                    end else if (rd_empty && wr_empty) begin
                        n_out.status = ST_EMPTY;
                    end else begin
                        rd_pop                = !take_write;
                        wr_pop                = take_write;
                        n_outstanding         = 1'b1;
                        n_out.dispatched      = 1'b1;
                        n_out.issued_is_write = take_write;
                        n_out.issued_tag      = take_write ? wr_head.tag : rd_head.tag;
                    end
                end
                ACT_COMPLETE: begin
                    n_outstanding = 1'b0;
                end
                ACT_TICK: begin
                    n_time = r_time + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // control and configuration state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid        <= 1'b0;
            r_out_valid       <= 1'b0;
            r_time            <= '0;
            r_outstanding     <= 1'b0;
            r_rd_deadline     <= DEADLINE_RESET;
            r_wr_deadline     <= DEADLINE_RESET;
            r_rd_predict_long <= 1'b1;
            r_wr_predict_gc   <= 1'b0;
        end else begin
            r_in_valid    <= i_start && !o_busy;
            r_out_valid   <= r_in_valid;
            r_time        <= n_time;
            r_outstanding <= n_outstanding;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_READ_DEADLINE:  r_rd_deadline     <= i_cfg_data;
                    CFG_WRITE_DEADLINE: r_wr_deadline     <= i_cfg_data;
                    CFG_READ_PREDICT:   r_rd_predict_long <= i_cfg_data[0];
                    CFG_WRITE_PREDICT:  r_wr_predict_gc   <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy) begin
            r_in <= i_cmd;
        end
        r_out <= n_out;
    end

    assign o_done   = r_out_valid;
    assign o_result = r_out;

    `RWDD_ASSERT_NXT(a_capture_to_result, i_clk, i_rst_n, r_in_valid, o_done, "captured command gave no result")
    `RWDD_ASSERT_IMP(a_idle_fields_zero, i_clk, i_rst_n, o_done && !o_result.dispatched, o_result.issued_tag == '0 && !o_result.issued_is_write, "stale issue fields")
    `RWDD_ASSERT_IMP(a_issue_status_ok, i_clk, i_rst_n, o_done && o_result.dispatched, o_result.status == ST_OK, "issue with error status")
    `RWDD_ASSERT_NXT(a_issue_sets_flight, i_clk, i_rst_n, rd_pop || wr_pop, r_outstanding, "issue left nothing in flight")

endmodule
